// ===== hw/rtl/tsq_pkg.sv =====
// ----------------------------------------------------------------------------
// tsq_pkg
// shared types and codes for the two-stack queue: operation and status codes,
// and the command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package tsq_pkg;

    localparam int DEPTH_DEF      = 8;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int MODE_W         = 2;
    localparam int FIELD_W        = 32;

    localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // where the result word comes from
    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_POP  = 2'd1,
        RES_MOVE = 2'd2
    } res_sel_t;

    typedef struct packed {
        logic     item_load;
        logic     push_wr;
        logic     push_rd;
        logic     pop_wr;
        logic     pop_rd;
        logic     pop_dec;
        res_sel_t res_sel;
        status_t  res_status;
        logic     res_capture;
        logic     out_load;
        logic     out_from_hold;
    } dp_cmd_t;

    typedef struct packed {
        logic is_enq;
        logic is_deq;
        logic is_peek;
        logic push_full;
        logic push_empty;
        logic pop_empty;
    } dp_status_t;

endpackage

// ===== hw/rtl/tsq_ram.sv =====
// ----------------------------------------------------------------------------
// tsq_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module tsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tsq_datapath.sv =====
// ----------------------------------------------------------------------------
// tsq_datapath
// item register, the two stack memories with their counts, and the result and
// output registers
// ----------------------------------------------------------------------------
module tsq_datapath #(
    parameter int DEPTH      = tsq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = tsq_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tsq_pkg::dp_cmd_t             dp_cmd,
    output tsq_pkg::dp_status_t          dp_status,
    input  logic [tsq_pkg::MODE_W-1:0]   mode,
    input  logic [tsq_pkg::FIELD_W-1:0]  value,
    output logic [tsq_pkg::FIELD_W-1:0]  data_out,
    output logic [1:0]                   status
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_W = tsq_pkg::FIELD_W;

    logic [tsq_pkg::MODE_W-1:0] mode_reg;
    logic [DATA_WIDTH-1:0]      value_reg;

    logic [CW-1:0] push_cnt_reg, push_cnt_next;
    logic [CW-1:0] pop_cnt_reg, pop_cnt_next;
    logic [CW-1:0] push_top;
    logic [CW-1:0] pop_top;

    logic [DATA_WIDTH-1:0] push_rdata;
    logic [DATA_WIDTH-1:0] pop_rdata;
    logic [DATA_WIDTH-1:0] res_word;
    logic [OUT_W-1:0]      res_out;

    logic [OUT_W-1:0]  res_data_reg;
    tsq_pkg::status_t  res_status_reg;
    logic [OUT_W-1:0]  data_out_reg;
    tsq_pkg::status_t  status_reg;

    assign push_top = push_cnt_reg - CW'(1);
    assign pop_top  = pop_cnt_reg - CW'(1);

    tsq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_push_ram (
        .clk   (clk),
        .we    (dp_cmd.push_wr),
        .waddr (push_cnt_reg[AW-1:0]),
        .wdata (value_reg),
        .re    (dp_cmd.push_rd),
        .raddr (push_top[AW-1:0]),
        .rdata (push_rdata)
    );

    // refill moves the word just read from the push stack straight across
    tsq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_pop_ram (
        .clk   (clk),
        .we    (dp_cmd.pop_wr),
        .waddr (pop_cnt_reg[AW-1:0]),
        .wdata (push_rdata),
        .re    (dp_cmd.pop_rd),
        .raddr (pop_top[AW-1:0]),
        .rdata (pop_rdata)
    );

    always_comb
    begin
        push_cnt_next = push_cnt_reg;
        if (dp_cmd.push_wr)
        begin
            push_cnt_next = push_cnt_reg + CW'(1);
        end
        else if (dp_cmd.push_rd)
        begin
            push_cnt_next = push_cnt_reg - CW'(1);
        end
    end

    // a dequeue on the last refill step writes and pops in the same cycle
    always_comb
    begin
        case ({dp_cmd.pop_wr, dp_cmd.pop_dec})
            2'b10:   pop_cnt_next = pop_cnt_reg + CW'(1);
            2'b01:   pop_cnt_next = pop_cnt_reg - CW'(1);
            default: pop_cnt_next = pop_cnt_reg;
        endcase
    end

    always_comb
    begin
        case (dp_cmd.res_sel)
            tsq_pkg::RES_POP:  res_word = pop_rdata;
            tsq_pkg::RES_MOVE: res_word = push_rdata;
            default:           res_word = '0;
        endcase
    end

    assign res_out = OUT_W'(res_word);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_cnt_reg <= '0;
            pop_cnt_reg  <= '0;
        end
        else
        begin
            push_cnt_reg <= push_cnt_next;
            pop_cnt_reg  <= pop_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.item_load)
        begin
            mode_reg  <= mode;
            value_reg <= DATA_WIDTH'(value);
        end
        if (dp_cmd.res_capture)
        begin
            res_data_reg   <= res_out;
            res_status_reg <= dp_cmd.res_status;
        end
        if (dp_cmd.out_load)
        begin
            if (dp_cmd.out_from_hold)
            begin
                data_out_reg <= res_data_reg;
                status_reg   <= res_status_reg;
            end
            else
            begin
                data_out_reg <= res_out;
                status_reg   <= dp_cmd.res_status;
            end
        end
    end

    assign dp_status.is_enq     = (mode_reg == tsq_pkg::MODE_ENQ);
    assign dp_status.is_deq     = (mode_reg == tsq_pkg::MODE_DEQ);
    assign dp_status.is_peek    = (mode_reg == tsq_pkg::MODE_PEEK);
    assign dp_status.push_full  = (push_cnt_reg == CW'(DEPTH));
    assign dp_status.push_empty = (push_cnt_reg == '0);
    assign dp_status.pop_empty  = (pop_cnt_reg == '0);

    assign data_out = data_out_reg;
    assign status   = status_reg;

`ifndef SYNTHESIS
    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt_reg <= CW'(DEPTH)) && (pop_cnt_reg <= CW'(DEPTH)))
        else $error("stack count beyond depth");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.push_wr |-> !dp_status.push_full)
        else $error("push onto full input stack");

    a_push_rd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.push_rd |-> !dp_status.push_empty && !dp_cmd.push_wr)
        else $error("read from empty input stack");

    a_pop_access_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.pop_rd |-> !dp_status.pop_empty) and
        (dp_cmd.pop_wr |-> pop_cnt_reg < CW'(DEPTH)))
        else $error("bad access to output stack");
`endif

endmodule

// ===== hw/rtl/tsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsq_ctrl
// sequencer for one item at a time: decode, stack refill walk, result hand-off
// ----------------------------------------------------------------------------
module tsq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  tsq_pkg::dp_status_t  dp_status,
    output tsq_pkg::dp_cmd_t     dp_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_READ,
        S_MOVE,
        S_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   finish;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        dp_cmd            = '0;
        dp_cmd.res_sel    = tsq_pkg::RES_ZERO;
        dp_cmd.res_status = tsq_pkg::ST_OK;
        state_next        = state_reg;
        finish            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.item_load = 1'b1;
                    state_next       = S_CMD;
                end
            end
            S_CMD:
            begin
                if (dp_status.is_enq)
                begin
                    finish = 1'b1;
                    if (dp_status.push_full)
                    begin
                        dp_cmd.res_status = tsq_pkg::ST_FULL;
                    end
                    else
                    begin
                        dp_cmd.push_wr = 1'b1;
                    end
                end
                else if (dp_status.is_deq || dp_status.is_peek)
                begin
                    if (!dp_status.pop_empty)
                    begin
                        dp_cmd.pop_rd = 1'b1;
                        state_next    = S_READ;
                    end
                    else if (dp_status.push_empty)
                    begin
                        finish            = 1'b1;
                        dp_cmd.res_status = tsq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        dp_cmd.push_rd = 1'b1;
                        state_next     = S_MOVE;
                    end
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            S_READ:
            begin
                finish         = 1'b1;
                dp_cmd.res_sel = tsq_pkg::RES_POP;
                dp_cmd.pop_dec = dp_status.is_deq;
            end
            S_MOVE:
            begin
                // one word a cycle; the last word moved is the new front
                dp_cmd.pop_wr = 1'b1;
                if (!dp_status.push_empty)
                begin
                    dp_cmd.push_rd = 1'b1;
                end
                else
                begin
                    finish         = 1'b1;
                    dp_cmd.res_sel = tsq_pkg::RES_MOVE;
                    dp_cmd.pop_dec = dp_status.is_deq;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    dp_cmd.out_load      = 1'b1;
                    dp_cmd.out_from_hold = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            if (out_free)
            begin
                dp_cmd.out_load = 1'b1;
                state_next      = S_IDLE;
            end
            else
            begin
                dp_cmd.res_capture = 1'b1;
                state_next         = S_HOLD;
            end
        end
    end

    always_comb
    begin
        if (dp_cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("pending result lost");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |=> state_reg == S_IDLE)
        else $error("result loaded while item still in work");

    a_hold_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> out_valid_reg)
        else $error("holding a result with the output register empty");
`endif

endmodule

// ===== hw/rtl/two_stack_queue.sv =====
// ----------------------------------------------------------------------------
// two_stack_queue
// first-in first-out queue made of two bounded stacks held in RAM
// ----------------------------------------------------------------------------
// One item is taken at a time and gives exactly one result. After acceptance
// in S_IDLE an enqueue, or an operation on an empty queue or on the unused
// mode, finishes in S_CMD; a dequeue or peek served from a non-empty output
// stack reads it in S_CMD and finishes in S_READ; a dequeue or peek that
// finds the output stack empty refills it in S_MOVE with the n words on the
// input stack (up to DEPTH), one word a cycle through the read port of the
// input stack RAM and the write port of the output stack RAM.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled output only delays the item after that one.
module two_stack_queue #(
    parameter int DEPTH      = tsq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = tsq_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tsq_pkg::MODE_W-1:0]   mode,
    input  logic [tsq_pkg::FIELD_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tsq_pkg::FIELD_W-1:0]  data_out,
    output logic [1:0]                   status
);

    tsq_pkg::dp_cmd_t    dp_cmd;
    tsq_pkg::dp_status_t dp_status;

    tsq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .mode      (mode),
        .value     (value),
        .data_out  (data_out),
        .status    (status)
    );

    tsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

endmodule
